// ===== rtl/core/command_line_tokenizer_core_defines.svh =====
// Assertion macros shared by the command line tokenizer RTL.
// Include by bare file name; no other dependencies.
`ifndef COMMAND_LINE_TOKENIZER_CORE_DEFINES_SVH
`define COMMAND_LINE_TOKENIZER_CORE_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define CLT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define CLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/clt_pkg.sv =====
// Shared types and constants of the command line tokenizer.
// No dependencies; imported by every module of the block.
package clt_pkg;

    // Header layout and minimum line lengths
    localparam int CID_CHARS         = (8 * 8 + 7) / 5;
    localparam int PLAIN_BODY_START  = 5;
    localparam int PLAIN_MIN_LEN     = PLAIN_BODY_START + CID_CHARS;
    localparam int LEGACY_MIN_LEN    = 7;
    localparam int LEGACY_CMD_START  = 4;
    localparam int LEGACY_BODY_START = 8;
    localparam int CMD_LEN           = 3;

    localparam int POS_W   = 5;
    localparam int LEN_W   = POS_W + 1;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Characters
    localparam logic [7:0] CHAR_S   = 8'h73;
    localparam logic [7:0] CHAR_N   = 8'h6E;
    localparam logic [7:0] CHAR_BSL = 8'h5C;
    localparam logic [7:0] CHAR_SP  = 8'h20;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    // Register reset values
    localparam logic [7:0] RST_CLIENT_CODE  = 8'd67;
    localparam logic [7:0] RST_DIRECT_CODE  = 8'd68;
    localparam logic [7:0] RST_FEATURE_CODE = 8'd70;

    // Result queue
    localparam int MAX_RESULTS = 3;
    localparam int RES_CNT_W   = 2;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    typedef enum logic [1:0] {
        REG_CLIENT  = 2'd0,
        REG_DIRECT  = 2'd1,
        REG_FEATURE = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        KIND_TYPE   = 3'd0,
        KIND_CMD    = 3'd1,
        KIND_DATA   = 3'd2,
        KIND_END    = 3'd3,
        KIND_STATUS = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CLS_SOURCE  = 2'd0,
        CLS_TARGET  = 2'd1,
        CLS_FEATURE = 2'd2,
        CLS_PARAM   = 2'd3
    } t_class;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_SHORT   = 2'd1,
        ST_ESC_END = 2'd2,
        ST_BAD_ESC = 2'd3
    } t_status;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
        t_class     cls;
        t_status    status;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             legacy;
        logic [7:0]       line_type;
        logic             esc;
        logic             src;
        logic             tgt;
        logic             feat;
        logic             tne;
        t_status          err;
    } t_tok_state;

    typedef struct packed {
        logic [7:0] client;
        logic [7:0] direct;
        logic [7:0] feature;
    } t_cfg;

endpackage

// ===== rtl/core/clt_decode.sv =====
// Per-byte decode of the command line tokenizer: next state and up to three results.
// Depends on clt_pkg.
module clt_decode
    import clt_pkg::*;
(
    input  t_tok_state          i_state,
    input  t_cfg                i_cfg,
    input  logic [7:0]          i_byte,
    input  logic                i_first,
    input  logic                i_last,
    input  logic                i_legacy,
    output t_tok_state          o_state,
    output t_result             o_res [MAX_RESULTS],
    output logic [RES_CNT_W-1:0] o_cnt
);

    t_tok_state        s;
    logic              first;
    logic [POS_W-1:0]  pos;
    logic              body_en;
    logic              is_direct;
    logic              is_feature;
    t_class            sp_cls;
    t_class            fin_cls;
    logic [7:0]        esc_d;
    logic              esc_ok;
    logic [LEN_W-1:0]  len;
    logic [LEN_W-1:0]  min_len;
    t_status           st;
    t_result           cand [MAX_RESULTS];
    logic [MAX_RESULTS-1:0] vld;
    logic [RES_CNT_W-1:0] idx;

    always_comb begin
        s     = i_state;
        first = i_first || (i_state.pos == '0);
        if (first) begin
            s.pos       = '0;
            s.legacy    = i_legacy;
            s.line_type = i_legacy ? i_cfg.client : i_byte;
            s.esc       = 1'b0;
            s.src       = i_legacy;
            s.tgt       = 1'b0;
            s.feat      = 1'b0;
            s.tne       = 1'b0;
            s.err       = ST_OK;
        end
        pos        = s.pos;
        is_direct  = (s.line_type == i_cfg.direct);
        is_feature = (s.line_type == i_cfg.feature);

        // Class a space would give the current token
        if (!s.src)                    sp_cls = CLS_SOURCE;
        else if (is_direct && !s.tgt)  sp_cls = CLS_TARGET;
        else if (is_feature && !s.feat) sp_cls = CLS_FEATURE;
        else                           sp_cls = CLS_PARAM;

        // Escape decode
        esc_ok = 1'b1;
        esc_d  = CHAR_SP;
        if (i_byte == CHAR_S)                  esc_d = CHAR_SP;
        else if (i_byte == CHAR_N)             esc_d = CHAR_LF;
        else if (i_byte == CHAR_BSL)           esc_d = CHAR_BSL;
        else if (i_byte == CHAR_SP && s.legacy) esc_d = CHAR_SP;
        else                                   esc_ok = 1'b0;

        cand[0] = '0;
        cand[1] = '0;
        cand[2] = '0;
        vld     = '0;
        body_en = 1'b0;

        // Header or body result
        if (pos == '0) begin
            vld[0]       = 1'b1;
            cand[0].kind = KIND_TYPE;
            cand[0].data = s.line_type;
        end else if (s.legacy) begin
            if (pos >= POS_W'(LEGACY_CMD_START) && pos < POS_W'(LEGACY_CMD_START + CMD_LEN)) begin
                vld[0]       = 1'b1;
                cand[0].kind = KIND_CMD;
                cand[0].data = i_byte;
            end else if (pos >= POS_W'(LEGACY_BODY_START)) begin
                body_en = 1'b1;
            end
        end else begin
            if (pos <= POS_W'(CMD_LEN)) begin
                vld[0]       = 1'b1;
                cand[0].kind = KIND_CMD;
                cand[0].data = i_byte;
            end else if (pos >= POS_W'(PLAIN_BODY_START)) begin
                body_en = 1'b1;
            end
        end

        if (body_en && s.err == ST_OK) begin
            if (s.esc) begin
                s.esc = 1'b0;
                if (esc_ok) begin
                    vld[0]       = 1'b1;
                    cand[0].kind = KIND_DATA;
                    cand[0].data = esc_d;
                    cand[0].cls  = sp_cls;
                    s.tne        = 1'b1;
                end else begin
                    s.err = ST_BAD_ESC;
                end
            end else if (i_byte == CHAR_BSL) begin
                s.esc = 1'b1;
            end else if (i_byte == CHAR_SP) begin
                vld[0]       = 1'b1;
                cand[0].kind = KIND_END;
                cand[0].cls  = sp_cls;
                case (sp_cls)
                    CLS_SOURCE:  s.src  = 1'b1;
                    CLS_TARGET:  s.tgt  = 1'b1;
                    CLS_FEATURE: s.feat = 1'b1;
                    default:     ;
                endcase
                s.tne = 1'b0;
            end else begin
                vld[0]       = 1'b1;
                cand[0].kind = KIND_DATA;
                cand[0].data = i_byte;
                cand[0].cls  = sp_cls;
                s.tne        = 1'b1;
            end
        end

        // Final token class, from the flags after this byte
        if (!s.src)                    fin_cls = CLS_SOURCE;
        else if (is_direct && !s.tgt)  fin_cls = CLS_TARGET;
        else                           fin_cls = CLS_PARAM;

        len     = {1'b0, pos} + LEN_W'(1);
        min_len = s.legacy ? LEN_W'(LEGACY_MIN_LEN) : LEN_W'(PLAIN_MIN_LEN);
        st      = ST_OK;

        if (i_last) begin
            if (len < min_len)        st = ST_SHORT;
            else if (s.err != ST_OK)  st = s.err;
            else if (s.esc)           st = ST_ESC_END;
            else if (s.tne) begin
                vld[1]       = 1'b1;
                cand[1].kind = KIND_END;
                cand[1].cls  = fin_cls;
                case (fin_cls)
                    CLS_SOURCE: s.src = 1'b1;
                    CLS_TARGET: s.tgt = 1'b1;
                    default:    ;
                endcase
                s.tne = 1'b0;
            end
            vld[2]         = 1'b1;
            cand[2].kind   = KIND_STATUS;
            cand[2].status = st;
            s.pos          = '0;
        end else begin
            s.pos = (pos < POS_MAX) ? pos + POS_W'(1) : POS_MAX;
        end

        cand[0].last = !vld[1] && !vld[2];
        cand[1].last = !vld[2];
        cand[2].last = 1'b1;

        // Pack valid candidates to the front
        o_res[0] = '0;
        o_res[1] = '0;
        o_res[2] = '0;
        idx      = '0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (vld[k]) begin
                o_res[idx] = cand[k];
                idx        = idx + RES_CNT_W'(1);
            end
        end
        o_cnt   = idx;
        o_state = s;
    end

endmodule

// ===== rtl/core/clt_resq.sv =====
// Small result queue: takes up to three results a cycle, hands out one beat a cycle while the receiver is ready.
// Depends on clt_pkg and the assertion macro header.
`include "command_line_tokenizer_core_defines.svh"

module clt_resq
    import clt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [RES_CNT_W-1:0] i_wr_cnt,
    input  t_result              i_wr_item [MAX_RESULTS],
    output logic                 o_room,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_result              o_item
);

    t_result              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic [Q_PTR_W-1:0]   n_wr_ptr;
    logic [Q_PTR_W-1:0]   n_rd_ptr;
    logic [Q_CNT_W-1:0]   n_count;
    logic                 pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    // Room for a full burst of results
    assign o_room  = (r_count <= Q_CNT_W'(Q_DEPTH - MAX_RESULTS));

    always_comb begin
        n_wr_ptr = r_wr_ptr + Q_PTR_W'(i_wr_cnt);
        n_rd_ptr = r_rd_ptr + Q_PTR_W'(pop);
        n_count  = r_count + Q_CNT_W'(i_wr_cnt) - Q_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (RES_CNT_W'(k) < i_wr_cnt) begin
                r_mem[r_wr_ptr + Q_PTR_W'(k)] <= i_wr_item[k];
            end
        end
    end

    `CLT_ASSERT(a_no_overflow, i_clk, i_rst_n, (i_wr_cnt != '0) |-> (Q_CNT_W'(r_count) + Q_CNT_W'(i_wr_cnt) <= Q_CNT_W'(Q_DEPTH)), "result queue overflow")
    `CLT_ASSERT(a_ptr_match, i_clk, i_rst_n, (r_wr_ptr - r_rd_ptr) == r_count[Q_PTR_W-1:0], "queue pointers disagree with count")
    `CLT_ASSERT_ALWAYS(a_count_range, i_clk, !i_rst_n || (r_count <= Q_CNT_W'(Q_DEPTH)), "queue count beyond depth")

endmodule

// ===== rtl/core/command_line_tokenizer_core.sv =====
// Top level of the command line tokenizer: stream ports, config registers, line state.
// Depends on clt_pkg, clt_decode, clt_resq and the assertion macro header.
//
// Usage:
//   Slave stream carries one raw line byte per beat: tdata[7:0] is the byte,
//   tuser[0] marks the first byte of a line, tuser[1] selects legacy framing
//   (sampled at the line start), tlast marks the final byte of the line.
//   Master stream carries one result per beat: tuser[2:0] is the item kind
//   (type byte, command byte, token data, token end, line status), tdata holds
//   the decoded byte, the token class and the line status, and tlast flags the
//   last result caused by one input byte.
//   Each byte is decoded in the cycle it is accepted; its results are
//   registered into a four-entry result queue that feeds the master side.
//   One byte per cycle is sustained while each byte gives at most one result
//   and the receiver is ready; a line-end byte gives up to three results and
//   the queue drains them at one per cycle while the receiver is ready. tready
//   is high while the queue holds at most one result, so the receiver may stall
//   at will: results wait in the queue and input backs up once it fills.
//   Reset clears the line state and the queue and loads the type code
//   registers with 67, 68 and 70. Write registers only while the block is idle.
`include "command_line_tokenizer_core_defines.svh"

module command_line_tokenizer_core
    import clt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Slave stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] line_byte
    input  logic [1:0]  i_s_axis_tuser,   // [0] first_byte, [1] legacy_framing
    input  logic        i_s_axis_tlast,   // last_byte
    // Master stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] data_byte, [9:8] token_class,
                                          // [11:10] status, [15:12] zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] item_kind
    output logic        o_m_axis_tlast,   // last_of_run
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata
);

    t_cfg                 r_cfg;
    t_tok_state           r_state;
    t_tok_state           n_state;
    t_result              dec_res [MAX_RESULTS];
    logic [RES_CNT_W-1:0] dec_cnt;
    logic [RES_CNT_W-1:0] wr_cnt;
    logic                 q_room;
    logic                 accept;
    t_result              head;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = q_room;

    // Config registers: index outside the list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.client  <= RST_CLIENT_CODE;
            r_cfg.direct  <= RST_DIRECT_CODE;
            r_cfg.feature <= RST_FEATURE_CODE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CLIENT:  r_cfg.client  <= i_cfg_wdata;
                REG_DIRECT:  r_cfg.direct  <= i_cfg_wdata;
                REG_FEATURE: r_cfg.feature <= i_cfg_wdata;
                default:     ;
            endcase
        end
    end

    clt_decode u_decode (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_byte   (i_s_axis_tdata),
        .i_first  (i_s_axis_tuser[0]),
        .i_last   (i_s_axis_tlast),
        .i_legacy (i_s_axis_tuser[1]),
        .o_state  (n_state),
        .o_res    (dec_res),
        .o_cnt    (dec_cnt)
    );

    // Advance the line state only on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    assign wr_cnt = accept ? dec_cnt : '0;

    clt_resq u_resq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_cnt  (wr_cnt),
        .i_wr_item (dec_res),
        .o_room    (q_room),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_item    (head)
    );

    assign o_m_axis_tdata = {4'b0000, head.status, head.cls, head.data};
    assign o_m_axis_tuser = head.kind;
    assign o_m_axis_tlast = head.last;

    `CLT_ASSERT(a_pos_after_last, i_clk, i_rst_n, (accept && i_s_axis_tlast) |=> (r_state.pos == '0), "position not cleared after line end")
    `CLT_ASSERT(a_err_holds_esc, i_clk, i_rst_n, (r_state.err == ST_BAD_ESC) |-> !r_state.esc, "escape pending after unknown escape")
    `CLT_ASSERT(a_line_end_results, i_clk, i_rst_n, (accept && i_s_axis_tlast) |-> (dec_cnt != '0) && dec_res[dec_cnt - RES_CNT_W'(1)].kind == KIND_STATUS, "line end without status result")

endmodule
